/* design/wbgs_pkg.sv */
package wbgs_pkg;

    localparam int MAG_BITS       = 20;
    localparam int MOD_STAGES     = MAG_BITS / 2;
    localparam int COL_BITS       = 10;
    localparam int ROW_BITS       = 9;
    localparam int FULL_ADDR_BITS = 19;
    localparam int FIFO_DEPTH     = 32;
    localparam int FIFO_AW        = 5;

    localparam logic signed [26:0] HALF_TURN = 27'sd11796480;
    localparam logic signed [26:0] FULL_TURN = 27'sd23592960;
    localparam logic signed [24:0] LAT_MAX   = 25'sd5898240;
    localparam logic signed [24:0] LAT_MIN   = -25'sd5898240;
    localparam logic signed [24:0] OUT_MAX   = 25'sd8388607;
    localparam logic signed [24:0] OUT_MIN   = -25'sd8388608;

    typedef enum logic [2:0] {
        CFG_ORIGIN_LON   = 3'd0,
        CFG_ORIGIN_LAT   = 3'd1,
        CFG_INV_STEP_LON = 3'd2,
        CFG_INV_STEP_LAT = 3'd3,
        CFG_COLS_IN_USE  = 3'd4,
        CFG_ROWS_IN_USE  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic signed [24:0] origin_lon;
        logic signed [23:0] origin_lat;
        logic [23:0]        inv_lon;
        logic [23:0]        inv_lat;
        logic [COL_BITS-1:0] cols;
        logic [ROW_BITS-1:0] rows;
    } t_cfg;

    typedef struct packed {
        logic               vld;
        logic               smp;
        logic [15:0]        idx;
        logic signed [23:0] val;
    } t_tag;

    typedef struct packed {
        t_tag                tag;
        logic                neg;
        logic [MAG_BITS-1:0] mag;
        logic [15:0]         a;
        logic [15:0]         b;
        logic [ROW_BITS-1:0] j0;
        logic [ROW_BITS-1:0] j1;
    } t_cell;

    typedef struct packed {
        t_tag                      tag;
        logic [15:0]               a;
        logic [15:0]               b;
        logic [FULL_ADDR_BITS-1:0] ad00;
        logic [FULL_ADDR_BITS-1:0] ad10;
        logic [FULL_ADDR_BITS-1:0] ad01;
        logic [FULL_ADDR_BITS-1:0] ad11;
    } t_rd;

endpackage

/* design/wbgs_coord.sv */
module wbgs_coord (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wbgs_pkg::t_cfg     i_cfg,
    input  wbgs_pkg::t_tag     i_tag,
    input  logic signed [25:0] i_lon,
    input  logic signed [24:0] i_lat,
    output wbgs_pkg::t_cell    o_cell
);
    import wbgs_pkg::*;

    function automatic logic [ROW_BITS-1:0] clamp_row(logic signed [19:0] jj,
                                                      logic [ROW_BITS-1:0] top);
        if (jj < 0) begin
            return '0;
        end else if (jj > $signed({11'b0, top})) begin
            return top;
        end else begin
            return jj[ROW_BITS-1:0];
        end
    endfunction

    // fold and clamp
    logic signed [26:0] lon_sh, lon_f;
    logic signed [24:0] n_lon, n_lat;
    t_tag               r1_tag;
    logic signed [24:0] r1_lon, r1_lat;

    always_comb begin
        lon_sh = 27'(i_lon) + HALF_TURN;
        if (lon_sh < 0) begin
            lon_f = lon_sh + FULL_TURN;
        end else if (lon_sh >= FULL_TURN) begin
            lon_f = lon_sh - FULL_TURN;
        end else begin
            lon_f = lon_sh;
        end
        n_lon = 25'(lon_f - HALF_TURN);
        if (i_lat < LAT_MIN) begin
            n_lat = LAT_MIN;
        end else if (i_lat > LAT_MAX) begin
            n_lat = LAT_MAX;
        end else begin
            n_lat = i_lat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag.vld <= 1'b0;
        end else begin
            r1_tag <= i_tag;
        end
        r1_lon <= n_lon;
        r1_lat <= n_lat;
    end

    // scale to cell coordinates, Q.32
    logic signed [25:0] dl, dv;
    logic signed [24:0] inv_lon_s, inv_lat_s;
    logic signed [50:0] n_u, n_v, r2_u, r2_v;
    t_tag               r2_tag;

    always_comb begin
        dl        = 26'(r1_lon) - 26'(i_cfg.origin_lon);
        dv        = 26'(r1_lat) - 26'(i_cfg.origin_lat);
        inv_lon_s = {1'b0, i_cfg.inv_lon};
        inv_lat_s = {1'b0, i_cfg.inv_lat};
        n_u       = dl * inv_lon_s;
        n_v       = dv * inv_lat_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag.vld <= 1'b0;
        end else begin
            r2_tag <= r1_tag;
        end
        r2_u <= n_u;
        r2_v <= n_v;
    end

    // split into index and weight, clamp rows
    logic signed [18:0]         ci, cj;
    logic signed [19:0]         ie, je, je1;
    logic [ROW_BITS-1:0]        nrows_top;
    t_cell                      n_cell;

    always_comb begin
        ci        = r2_u[50:32];
        cj        = r2_v[50:32];
        ie        = 20'(ci);
        je        = 20'(cj);
        je1       = je + 20'sd1;
        nrows_top = (i_cfg.rows == '0) ? '0 : i_cfg.rows - 9'd1;
        n_cell.tag = r2_tag;
        n_cell.neg = ie < 0;
        n_cell.mag = (ie < 0) ? MAG_BITS'(-ie) : MAG_BITS'(ie);
        n_cell.a   = r2_u[31:16];
        n_cell.b   = r2_v[31:16];
        n_cell.j0  = clamp_row(je, nrows_top);
        n_cell.j1  = clamp_row(je1, nrows_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_cell.tag.vld <= 1'b0;
        end else begin
            o_cell <= n_cell;
        end
    end

endmodule

/* design/wbgs_addr.sv */
module wbgs_addr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [wbgs_pkg::COL_BITS-1:0] i_cols,
    input  wbgs_pkg::t_cell               i_cell,
    output wbgs_pkg::t_rd                 o_rd
);
    import wbgs_pkg::*;

    typedef struct packed {
        t_cell               crd;
        logic [COL_BITS-1:0] rem;
    } t_mstage;

    typedef struct packed {
        t_tag                tag;
        logic [15:0]         a;
        logic [15:0]         b;
        logic [ROW_BITS-1:0] j0;
        logic [ROW_BITS-1:0] j1;
        logic [COL_BITS-1:0] i0;
        logic [COL_BITS-1:0] i1;
    } t_fix;

    function automatic logic [COL_BITS-1:0] mod_step(logic [COL_BITS-1:0] rem, logic bt,
                                                      logic [COL_BITS-1:0] n);
        logic [COL_BITS:0] t;
        t = {rem, bt};
        if (t >= {1'b0, n}) begin
            t = t - {1'b0, n};
        end
        return t[COL_BITS-1:0];
    endfunction

    logic [COL_BITS-1:0] ncols;
    assign ncols = (i_cols == '0) ? COL_BITS'(1) : i_cols;

    // column remainder, two bits per stage
    t_mstage s_src [MOD_STAGES];
    t_mstage n_st  [MOD_STAGES];
    t_mstage r_st  [MOD_STAGES];

    assign s_src[0] = '{crd: i_cell, rem: '0};

    for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
        if (k > 0) begin : g_link
            assign s_src[k] = r_st[k-1];
        end
        always_comb begin
            n_st[k]      = s_src[k];
            n_st[k].rem  = mod_step(mod_step(s_src[k].rem,
                                             s_src[k].crd.mag[MAG_BITS-1-2*k], ncols),
                                    s_src[k].crd.mag[MAG_BITS-2-2*k], ncols);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].crd.tag.vld <= 1'b0;
            end else begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // wrap to [0, ncols) and next column
    t_mstage             fin;
    logic [COL_BITS:0]   inc;
    t_fix                n_fx, r_fx;

    always_comb begin
        fin       = r_st[MOD_STAGES-1];
        n_fx.tag  = fin.crd.tag;
        n_fx.a    = fin.crd.a;
        n_fx.b    = fin.crd.b;
        n_fx.j0   = fin.crd.j0;
        n_fx.j1   = fin.crd.j1;
        n_fx.i0   = (fin.crd.neg && fin.rem != '0) ? ncols - fin.rem : fin.rem;
        inc       = {1'b0, n_fx.i0} + 11'd1;
        n_fx.i1   = (inc == {1'b0, ncols}) ? '0 : inc[COL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx.tag.vld <= 1'b0;
        end else begin
            r_fx <= n_fx;
        end
    end

    // row * cols + col
    logic [FULL_ADDR_BITS-1:0] p0, p1;
    t_rd                       n_rd;

    always_comb begin
        p0        = FULL_ADDR_BITS'(r_fx.j0) * FULL_ADDR_BITS'(ncols);
        p1        = FULL_ADDR_BITS'(r_fx.j1) * FULL_ADDR_BITS'(ncols);
        n_rd.tag  = r_fx.tag;
        n_rd.a    = r_fx.a;
        n_rd.b    = r_fx.b;
        n_rd.ad00 = p0 + FULL_ADDR_BITS'(r_fx.i0);
        n_rd.ad10 = p0 + FULL_ADDR_BITS'(r_fx.i1);
        n_rd.ad01 = p1 + FULL_ADDR_BITS'(r_fx.i0);
        n_rd.ad11 = p1 + FULL_ADDR_BITS'(r_fx.i1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rd.tag.vld <= 1'b0;
        end else begin
            o_rd <= n_rd;
        end
    end

endmodule

/* design/wbgs_grid.sv */
module wbgs_grid #(
    parameter int GRID_CELLS = 65536,
    parameter int VALUE_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wbgs_pkg::t_rd                i_rd,
    output logic                         o_vld,
    output logic [15:0]                  o_a,
    output logic [15:0]                  o_b,
    output logic signed [VALUE_BITS-1:0] o_f00,
    output logic signed [VALUE_BITS-1:0] o_f10,
    output logic signed [VALUE_BITS-1:0] o_f01,
    output logic signed [VALUE_BITS-1:0] o_f11
);
    import wbgs_pkg::*;

    localparam int AW = $clog2(GRID_CELLS);

    // four copies, one read port each
    logic signed [VALUE_BITS-1:0] r_mem0 [GRID_CELLS];
    logic signed [VALUE_BITS-1:0] r_mem1 [GRID_CELLS];
    logic signed [VALUE_BITS-1:0] r_mem2 [GRID_CELLS];
    logic signed [VALUE_BITS-1:0] r_mem3 [GRID_CELLS];

    logic [AW+FULL_ADDR_BITS-1:0] x00, x10, x01, x11;
    logic [AW+15:0]               xw;
    logic [AW-1:0]                ra00, ra10, ra01, ra11, wa;
    logic signed [VALUE_BITS+23:0] wide;
    logic signed [VALUE_BITS-1:0]  wv;
    logic                          we;

    always_comb begin
        x00  = {{AW{1'b0}}, i_rd.ad00};
        x10  = {{AW{1'b0}}, i_rd.ad10};
        x01  = {{AW{1'b0}}, i_rd.ad01};
        x11  = {{AW{1'b0}}, i_rd.ad11};
        xw   = {{AW{1'b0}}, i_rd.tag.idx};
        ra00 = x00[AW-1:0];
        ra10 = x10[AW-1:0];
        ra01 = x01[AW-1:0];
        ra11 = x11[AW-1:0];
        wa   = xw[AW-1:0];
        wide = (VALUE_BITS+24)'(i_rd.tag.val);
        wv   = wide[VALUE_BITS-1:0];
        we   = i_rd.tag.vld && !i_rd.tag.smp && (32'(i_rd.tag.idx) < GRID_CELLS);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem0[wa] <= wv;
            r_mem1[wa] <= wv;
            r_mem2[wa] <= wv;
            r_mem3[wa] <= wv;
        end
        o_f00 <= r_mem0[ra00];
        o_f10 <= r_mem1[ra10];
        o_f01 <= r_mem2[ra01];
        o_f11 <= r_mem3[ra11];
        o_a   <= i_rd.a;
        o_b   <= i_rd.b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_rd.tag.vld && i_rd.tag.smp;
        end
    end

endmodule

/* design/wbgs_blend.sv */
module wbgs_blend #(
    parameter int VALUE_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [15:0]                  i_a,
    input  logic [15:0]                  i_b,
    input  logic signed [VALUE_BITS-1:0] i_f00,
    input  logic signed [VALUE_BITS-1:0] i_f10,
    input  logic signed [VALUE_BITS-1:0] i_f01,
    input  logic signed [VALUE_BITS-1:0] i_f11,
    output logic                         o_vld,
    output logic signed [23:0]           o_value
);
    import wbgs_pkg::*;

    localparam int W0 = VALUE_BITS + 18;
    localparam int WD = VALUE_BITS + 19;
    localparam int WP = VALUE_BITS + 20;
    localparam int RW = VALUE_BITS + 38;
    localparam int QW = (VALUE_BITS + 6 > 25) ? VALUE_BITS + 6 : 25;

    // blend along columns
    logic signed [VALUE_BITS:0] df0, df1;
    logic signed [16:0]         as;
    logic signed [W0-1:0]       n_r0, n_r1, r_r0, r_r1;
    logic [15:0]                r1_b;
    logic                       r_v1;

    always_comb begin
        df0  = (VALUE_BITS+1)'(i_f10) - (VALUE_BITS+1)'(i_f00);
        df1  = (VALUE_BITS+1)'(i_f11) - (VALUE_BITS+1)'(i_f01);
        as   = {1'b0, i_a};
        n_r0 = (W0'(i_f00) <<< 16) + W0'(df0) * W0'(as);
        n_r1 = (W0'(i_f01) <<< 16) + W0'(df1) * W0'(as);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
        end
        r_r0 <= n_r0;
        r_r1 <= n_r1;
        r1_b <= i_b;
    end

    // row difference times b, split in two products
    logic signed [WD-1:0]     d;
    logic signed [WD-17:0]    dhi;
    logic signed [16:0]       bs;
    logic signed [WP-1:0]     n_ph, r_ph;
    logic [31:0]              n_pl, r_pl;
    logic signed [W0-1:0]     r2_r0;
    logic                     r_v2;

    always_comb begin
        d    = WD'(r_r1) - WD'(r_r0);
        dhi  = d[WD-1:16];
        bs   = {1'b0, r1_b};
        n_ph = WP'(dhi) * WP'(bs);
        n_pl = 32'(d[15:0]) * 32'(r1_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_ph  <= n_ph;
        r_pl  <= n_pl;
        r2_r0 <= r_r0;
    end

    // full sum, Q.32
    logic signed [RW-1:0] n_r, r_r;
    logic signed [32:0]   pls;
    logic                 r_v3;

    always_comb begin
        pls = {1'b0, r_pl};
        n_r = (RW'(r2_r0) <<< 16) + (RW'(r_ph) <<< 16) + RW'(pls);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_r <= n_r;
    end

    // round half up and saturate
    logic signed [RW-1:0]    t;
    logic signed [RW-33:0]   q;
    logic signed [QW-1:0]    qx;
    logic signed [23:0]      n_value;

    always_comb begin
        t  = r_r + (RW'(1) <<< 31);
        q  = t[RW-1:32];
        qx = QW'(q);
        if (qx < OUT_MIN) begin
            n_value = OUT_MIN[23:0];
        end else if (qx > OUT_MAX) begin
            n_value = OUT_MAX[23:0];
        end else begin
            n_value = qx[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_v3;
        end
        o_value <= n_value;
    end

endmodule

/* design/wrapped_bilinear_grid_sampler.sv */
// Bilinear sampler over a longitude/latitude grid held in on-chip memory. Items of both kinds
// (cell writes and samples) enter at one per cycle while input ready is high; a sample passes
// through the column remainder pipeline (two bits per stage), the address multiply, the registered
// memory read, four blend stages and the result queue. The grid is kept
// in four identical copies so that all four neighbours are read in the same cycle; every write
// goes to all four. GRID_CELLS must be a power of two. A 32-entry result queue absorbs output
// stalls; input ready drops only when 32 samples are in flight or queued. Grid contents are
// undefined until written.
module wrapped_bilinear_grid_sampler #(
    parameter int GRID_CELLS = 65536,
    parameter int VALUE_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [15:0]        i_cell_index,
    input  logic signed [23:0] i_cell_value,
    input  logic signed [25:0] i_lon_deg,
    input  logic signed [24:0] i_lat_deg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_interpolated_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [24:0]        i_cfg_data
);
    import wbgs_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_lon <= -25'sd11796480;
            r_cfg.origin_lat <= -24'sd5898240;
            r_cfg.inv_lon    <= 24'd65536;
            r_cfg.inv_lat    <= 24'd65536;
            r_cfg.cols       <= 10'd360;
            r_cfg.rows       <= 9'd180;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ORIGIN_LON:   r_cfg.origin_lon <= i_cfg_data;
                CFG_ORIGIN_LAT:   r_cfg.origin_lat <= i_cfg_data[23:0];
                CFG_INV_STEP_LON: r_cfg.inv_lon    <= i_cfg_data[23:0];
                CFG_INV_STEP_LAT: r_cfg.inv_lat    <= i_cfg_data[23:0];
                CFG_COLS_IN_USE:  r_cfg.cols       <= i_cfg_data[COL_BITS-1:0];
                CFG_ROWS_IN_USE:  r_cfg.rows       <= i_cfg_data[ROW_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // credit: samples in flight plus queued
    logic [FIFO_AW:0] r_cnt, n_cnt;
    logic             in_xfer, out_xfer;
    t_tag             in_tag;

    assign o_ready  = r_cnt < (FIFO_AW+1)'(FIFO_DEPTH);
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    always_comb begin
        in_tag.vld = in_xfer;
        in_tag.smp = i_action;
        in_tag.idx = i_cell_index;
        in_tag.val = i_cell_value;
        n_cnt = r_cnt + (FIFO_AW+1)'(in_xfer && i_action) - (FIFO_AW+1)'(out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    t_cell                        crd;
    t_rd                          rd;
    logic                         g_vld;
    logic [15:0]                  g_a, g_b;
    logic signed [VALUE_BITS-1:0] f00, f10, f01, f11;
    logic                         b_vld;
    logic signed [23:0]           b_value;

    wbgs_coord u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_tag   (in_tag),
        .i_lon   (i_lon_deg),
        .i_lat   (i_lat_deg),
        .o_cell  (crd)
    );

    wbgs_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cols  (r_cfg.cols),
        .i_cell  (crd),
        .o_rd    (rd)
    );

    wbgs_grid #(
        .GRID_CELLS (GRID_CELLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .o_vld   (g_vld),
        .o_a     (g_a),
        .o_b     (g_b),
        .o_f00   (f00),
        .o_f10   (f10),
        .o_f01   (f01),
        .o_f11   (f11)
    );

    wbgs_blend #(
        .VALUE_BITS (VALUE_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (g_vld),
        .i_a     (g_a),
        .i_b     (g_b),
        .i_f00   (f00),
        .i_f10   (f10),
        .i_f01   (f01),
        .i_f11   (f11),
        .o_vld   (b_vld),
        .o_value (b_value)
    );

    // result queue
    logic signed [23:0] r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_fcnt;

    always_ff @(posedge i_clk) begin
        if (b_vld) begin
            r_fifo[r_wp] <= b_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
        end else begin
            if (b_vld) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (out_xfer) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            r_fcnt <= r_fcnt + (FIFO_AW+1)'(b_vld) - (FIFO_AW+1)'(out_xfer);
        end
    end

    assign o_valid              = r_fcnt != '0;
    assign o_interpolated_value = r_fifo[r_rp];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("sample credit count above queue depth");

    a_queue_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_cnt)
        else $error("queued results exceed outstanding samples");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_vld |-> (r_fcnt < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("result arrives with queue full");

endmodule

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wbgs_pkg::*;

    class grid_scoreboard;
        logic signed [23:0] grid [65536];
        longint olon, olat, inv_lon, inv_lat, ncols, nrows;
        logic signed [23:0] expected_q [$];
        int errors;

        function new();
            olon = -11796480;
            olat = -5898240;
            inv_lon = 65536;
            inv_lat = 65536;
            ncols = 360;
            nrows = 180;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_reg r, logic [24:0] d);
            case (r)
                CFG_ORIGIN_LON:   olon = longint'($signed(d[24:0]));
                CFG_ORIGIN_LAT:   olat = longint'($signed(d[23:0]));
                CFG_INV_STEP_LON: inv_lon = longint'(d[23:0]);
                CFG_INV_STEP_LAT: inv_lat = longint'(d[23:0]);
                CFG_COLS_IN_USE:  ncols = longint'(d[9:0]);
                CFG_ROWS_IN_USE:  nrows = longint'(d[8:0]);
                default: ;
            endcase
        endfunction

        function longint fetch(longint col, longint row, longint nc);
            longint ad;
            ad = (row * nc + col) & 65535;
            return longint'(grid[ad]);
        endfunction

        function void note_item(bit act, logic [15:0] idx, logic signed [23:0] val,
                                logic signed [25:0] lon_in, logic signed [24:0] lat_in);
            longint lon, lat, u, v, i, j, a, b, nc, nr, i0, i1, j0, j1;
            longint f00, f10, f01, f11, r0, r1, r, q;
            if (!act) begin
                grid[idx] = val;
                return;
            end
            lon = (longint'(lon_in) + longint'(HALF_TURN)) % longint'(FULL_TURN);
            if (lon < 0) lon += longint'(FULL_TURN);
            lon -= longint'(HALF_TURN);
            lat = longint'(lat_in);
            if (lat < longint'(LAT_MIN)) lat = longint'(LAT_MIN);
            if (lat > longint'(LAT_MAX)) lat = longint'(LAT_MAX);
            u = (lon - olon) * inv_lon;
            v = (lat - olat) * inv_lat;
            i = u >>> 32;
            j = v >>> 32;
            a = (u >> 16) & 65535;
            b = (v >> 16) & 65535;
            nc = (ncols == 0) ? 1 : ncols;
            nr = (nrows == 0) ? 1 : nrows;
            i0 = i % nc;
            if (i0 < 0) i0 += nc;
            i1 = (i + 1) % nc;
            if (i1 < 0) i1 += nc;
            j0 = (j < 0) ? 0 : (j > nr - 1) ? nr - 1 : j;
            j1 = (j + 1 < 0) ? 0 : (j + 1 > nr - 1) ? nr - 1 : j + 1;
            f00 = fetch(i0, j0, nc);
            f10 = fetch(i1, j0, nc);
            f01 = fetch(i0, j1, nc);
            f11 = fetch(i1, j1, nc);
            r0 = f00 * (65536 - a) + f10 * a;
            r1 = f01 * (65536 - a) + f11 * a;
            r = r0 * (65536 - b) + r1 * b;
            q = (r + 64'sh80000000) >>> 32;
            if (q < longint'(OUT_MIN)) q = longint'(OUT_MIN);
            if (q > longint'(OUT_MAX)) q = longint'(OUT_MAX);
            expected_q.insert(expected_q.size(), q[23:0]);
        endfunction

        function void check_value(logic signed [23:0] got);
            logic signed [23:0] exp_v;
            if (expected_q.size() == 0) begin
                $error("interpolated_value: no result expected, actual %0d", got);
                errors++;
                return;
            end
            exp_v = expected_q.pop_front();
            if (got !== exp_v) begin
                $error("interpolated_value: expected %0d actual %0d", exp_v, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic               i_action = 0;
    logic [15:0]        i_cell_index = 0;
    logic signed [23:0] i_cell_value = 0;
    logic signed [25:0] i_lon_deg = 0;
    logic signed [24:0] i_lat_deg = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic signed [23:0] o_interpolated_value;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = 0;
    logic [24:0]        i_cfg_data = 0;

    grid_scoreboard sb = new();
    bit no_gap = 1;
    int results_seen = 0;

    wrapped_bilinear_grid_sampler DUT (.*);

    always #2 i_clk = ~i_clk;

    task automatic send_item(bit act, logic [15:0] idx, logic signed [23:0] val,
                             logic signed [25:0] lon, logic signed [24:0] lat);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_cell_index <= idx;
        i_cell_value <= val;
        i_lon_deg <= lon;
        i_lat_deg <= lat;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(act, idx, val, lon, lat);
    endtask

    task automatic write_cell(logic [15:0] idx, logic signed [23:0] val);
        send_item(1'b0, idx, val, '0, '0);
    endtask

    task automatic sample(longint lon, longint lat);
        send_item(1'b1, 16'($urandom), 24'($urandom), lon[25:0], lat[24:0]);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg r, longint d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= d[24:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(r, d[24:0]);
    endtask

    task automatic set_config(longint olon, longint olat, longint il, longint ia,
                              longint nc, longint nr);
        drain();
        cfg_write(CFG_ORIGIN_LON, olon);
        cfg_write(CFG_ORIGIN_LAT, olat);
        cfg_write(CFG_INV_STEP_LON, il);
        cfg_write(CFG_INV_STEP_LAT, ia);
        cfg_write(CFG_COLS_IN_USE, nc);
        cfg_write(CFG_ROWS_IN_USE, nr);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic longint rnd(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    task automatic random_items(int n);
        for (int k = 0; k < n; k++) begin
            no_gap = ($urandom_range(0, 9) == 0);
            if (k == n / 2) drain();
            if ($urandom_range(0, 3) == 0)
                write_cell(16'($urandom_range(0, 1023)), 24'($urandom));
            else if ($urandom_range(0, 4) == 0)
                sample(rnd(-11796480, 11796479), rnd(-5898240, 5898240));
            else
                sample(rnd(-23592960, 23592959), rnd(-11796480, 11796480));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
    end

    initial begin : receiver
        int gap;
        wait (i_rst_n);
        forever begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (results_seen == 100 || results_seen == 600) gap = 300;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_value(o_interpolated_value);
            results_seen++;
        end
    end

    // every configuration keeps cols * rows within the 512 cells written first
    initial begin
        longint nc, nr;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_config(-11796480, -5898240, 65536, 65536, 32, 16);
        no_gap = 1;
        for (int c = 0; c < 512; c++) begin
            write_cell(c[15:0], (c % 7 == 0) ? 24'sh7FFFFF : (c % 7 == 1) ? 24'sh800000
                                                           : 24'($urandom));
        end
        no_gap = 0;
        write_cell(16'h0000, 24'sh7FFFFF);
        write_cell(16'hFFFF, 24'sh800000);
        sample(-23592960, -11796480);
        sample(23592959, 11796480);
        sample(-11796480, -5898240);
        sample(11796480 - 1, 5898240);
        sample(11796480, 0);
        sample(-11796481, 5898241);
        sample(0, -5898241);
        sample(32768, 32768);
        sample(65536 * 359, 65536 * 179);
        sample(-1, -1);
        sample(23592959, 0);
        write_cell(16'd5, 24'sh000001);
        sample(-11796480 + 5 * 65536, -5898240);
        random_items(200);
        set_config(-11796480, -5898240, 1, 1, 1, 1);
        random_items(150);
        set_config(11796480, 5898240, 16777215, 16777215, 512, 1);
        random_items(150);
        set_config(0, 0, 32768, 32768, 16, 32);
        random_items(150);
        for (int p = 0; p < 5; p++) begin
            nc = rnd(1, 512);
            nr = rnd(1, (512 / nc > 256) ? 256 : 512 / nc);
            set_config(rnd(-11796480, 11796480), rnd(-5898240, 5898240),
                       rnd(1, 16777215), rnd(1, 262144), nc, nr);
            random_items(150);
        end
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #(4 * 3000000);
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
